// ===== design/bcd_pkg.sv =====
`default_nettype none

package bcd_pkg;

	localparam int unsigned IN_W   = 128;
	localparam int unsigned OUT_W  = 40;
	localparam int unsigned PART_W = 64;

	// format register codes
	localparam logic [1:0] FMT_BC1 = 2'd0;
	localparam logic [1:0] FMT_BC2 = 2'd1;
	localparam logic [1:0] FMT_BC3 = 2'd2;

	// truncating division by 3, 5 and 7 as multiply by reciprocal and shift;
	// exact over the sum ranges that reach them (<= 765, 1275, 1785)
	localparam logic [9:0]  RECIP3 = 10'd683;
	localparam int unsigned SHIFT3 = 11;
	localparam logic [10:0] RECIP5 = 11'd1639;
	localparam int unsigned SHIFT5 = 13;
	localparam logic [11:0] RECIP7 = 12'd2341;
	localparam int unsigned SHIFT7 = 14;

	function automatic logic [31:0][7:0] exp5_tab();
		logic [31:0][7:0] t;
		for (int i = 0; i < 32; i++) begin
			t[i] = 8'(i * 255 / 31);
		end
		return t;
	endfunction

	function automatic logic [63:0][7:0] exp6_tab();
		logic [63:0][7:0] t;
		for (int i = 0; i < 64; i++) begin
			t[i] = 8'(i * 255 / 63);
		end
		return t;
	endfunction

	localparam logic [31:0][7:0] EXP5_TAB = exp5_tab();
	localparam logic [63:0][7:0] EXP6_TAB = exp6_tab();

	// decoded palettes of one block plus the raw per-texel indices
	typedef struct packed {
		logic [3:0][2:0][7:0] rgb;   // entry, channel (0 red, 1 green, 2 blue)
		logic [7:0][7:0]      apal;  // BC3 alpha palette
		logic                 c_gt;  // four-colour block
		logic [31:0]          cidx;  // 2-bit colour indices
		logic [63:0]          araw;  // alpha data as received
	} pal_t;

endpackage

`default_nettype wire

// ===== design/bc1_bc2_bc3_block_decoder_core.sv =====
// The first texel of a block passes the capture, sums, palette, block and output registers;
// the other fifteen follow one a cycle while the output is not stalled.
// Blocks go out at one texel a cycle while the output is not stalled;
// the palette pipeline takes the next block while the current one is still being sent.
// Reset (arst_n low, asynchronous): all valid bits clear, format returns to BC1.
`default_nettype none

module bc1_bc2_bc3_block_decoder_core import bcd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// format register
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_wdata,     // format_mode
	// compressed block in
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,  // alpha_part[63:0], color_part[127:64]
	// texels out
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata,  // texel_index[3:0], red[11:4],
	                                             // green[19:12], blue[27:20],
	                                             // alpha[35:28], zero[39:36]
	output logic                  m_axis_tlast   // last
);

	logic [1:0] fmt_q;
	logic       pal_valid, pal_ready;
	pal_t       pal;

	// Hold the format; the user must change it only while no block is in flight (the
	// block itself does not enforce this), so the serializer reads it directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_BC1;
		end else if (cfg_we) begin
			fmt_q <= cfg_wdata;
		end
	end

	// Three stages: capture block, expand endpoints and form weighted sums,
	// then divide by reciprocal and assemble the colour and alpha palettes.
	bcd_palette_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.alpha_part (s_axis_tdata[PART_W-1:0]),
		.color_part (s_axis_tdata[IN_W-1:PART_W]),
		.pal_valid  (pal_valid),
		.pal_ready  (pal_ready),
		.pal        (pal)
	);

	// Hold one decoded block and walk its sixteen texels in raster order into
	// the output register; load the next block in the same cycle as the last
	// texel goes into the output register, so blocks run back to back.
	bcd_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fmt       (fmt_q),
		.pal_valid (pal_valid),
		.pal_ready (pal_ready),
		.pal       (pal),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== design/bcd_palette_pipe.sv =====
`default_nettype none

module bcd_palette_pipe import bcd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [PART_W-1:0] alpha_part,
	input  wire logic [PART_W-1:0] color_part,
	output logic                  pal_valid,
	input  wire logic             pal_ready,
	output pal_t                  pal
);

	typedef struct packed {
		logic [2:0][7:0]  e0;
		logic [2:0][7:0]  e1;
		logic [2:0][9:0]  s3a;   // 2*e0 + e1
		logic [2:0][9:0]  s3b;   // e0 + 2*e1
		logic [2:0][8:0]  s2;    // e0 + e1
		logic [7:0]       a0;
		logic [7:0]       a1;
		logic [5:0][10:0] as7;   // sevenths sums
		logic [3:0][10:0] as5;   // fifths sums
		logic             c_gt;
		logic             a_gt;
		logic [31:0]      cidx;
		logic [63:0]      araw;
	} sums_t;

	logic              v_s1, v_s2, v_s3;
	logic              en1, en2, en3;
	logic [PART_W-1:0] apart_s1, cpart_s1;
	sums_t             sums_d, sums_s2;
	pal_t              pal_d, pal_s3;

	// stall chain: a stage loads when empty or when it moves on
	assign en3      = !v_s3 || pal_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// stage 2: expand endpoints, compare, weighted sums
	always_comb begin
		logic [15:0] c0, c1;
		c0 = cpart_s1[15:0];
		c1 = cpart_s1[31:16];
		sums_d.e0[0] = EXP5_TAB[c0[15:11]];
		sums_d.e0[1] = EXP6_TAB[c0[10:5]];
		sums_d.e0[2] = EXP5_TAB[c0[4:0]];
		sums_d.e1[0] = EXP5_TAB[c1[15:11]];
		sums_d.e1[1] = EXP6_TAB[c1[10:5]];
		sums_d.e1[2] = EXP5_TAB[c1[4:0]];
		for (int ch = 0; ch < 3; ch++) begin
			sums_d.s3a[ch] = {1'b0, sums_d.e0[ch], 1'b0} + 10'(sums_d.e1[ch]);
			sums_d.s3b[ch] = 10'(sums_d.e0[ch]) + {1'b0, sums_d.e1[ch], 1'b0};
			sums_d.s2[ch]  = 9'(sums_d.e0[ch]) + 9'(sums_d.e1[ch]);
		end
		sums_d.a0 = apart_s1[7:0];
		sums_d.a1 = apart_s1[15:8];
		for (int i = 0; i < 6; i++) begin
			sums_d.as7[i] = 11'(sums_d.a0) * 11'(6 - i) + 11'(sums_d.a1) * 11'(1 + i);
		end
		for (int i = 0; i < 4; i++) begin
			sums_d.as5[i] = 11'(sums_d.a0) * 11'(4 - i) + 11'(sums_d.a1) * 11'(1 + i);
		end
		sums_d.c_gt = c0 > c1;
		sums_d.a_gt = sums_d.a0 > sums_d.a1;
		sums_d.cidx = cpart_s1[63:32];
		sums_d.araw = apart_s1;
	end

	// stage 3: divide by reciprocal, assemble palettes
	always_comb begin
		logic [19:0] p3a, p3b;
		logic [21:0] p5;
		logic [22:0] p7;
		pal_d      = '0;
		p3a        = '0;
		p3b        = '0;
		p5         = '0;
		p7         = '0;
		pal_d.c_gt = sums_s2.c_gt;
		pal_d.cidx = sums_s2.cidx;
		pal_d.araw = sums_s2.araw;
		for (int ch = 0; ch < 3; ch++) begin
			p3a = 20'(sums_s2.s3a[ch]) * 20'(RECIP3);
			p3b = 20'(sums_s2.s3b[ch]) * 20'(RECIP3);
			pal_d.rgb[0][ch] = sums_s2.e0[ch];
			pal_d.rgb[1][ch] = sums_s2.e1[ch];
			if (sums_s2.c_gt) begin
				pal_d.rgb[2][ch] = p3a[SHIFT3 +: 8];
				pal_d.rgb[3][ch] = p3b[SHIFT3 +: 8];
			end else begin
				pal_d.rgb[2][ch] = sums_s2.s2[ch][8:1];
				pal_d.rgb[3][ch] = 8'd0;
			end
		end
		pal_d.apal[0] = sums_s2.a0;
		pal_d.apal[1] = sums_s2.a1;
		if (sums_s2.a_gt) begin
			for (int i = 0; i < 6; i++) begin
				p7 = 23'(sums_s2.as7[i]) * 23'(RECIP7);
				pal_d.apal[2 + i] = p7[SHIFT7 +: 8];
			end
		end else begin
			for (int i = 0; i < 4; i++) begin
				p5 = 22'(sums_s2.as5[i]) * 22'(RECIP5);
				pal_d.apal[2 + i] = p5[SHIFT5 +: 8];
			end
			pal_d.apal[6] = 8'd0;
			pal_d.apal[7] = 8'd255;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			apart_s1 <= alpha_part;
			cpart_s1 <= color_part;
		end
		if (en2) sums_s2 <= sums_d;
		if (en3) pal_s3  <= pal_d;
	end

	assign pal_valid = v_s3;
	assign pal       = pal_s3;

endmodule

`default_nettype wire

// ===== design/bcd_serializer.sv =====
`default_nettype none

module bcd_serializer import bcd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [1:0]       fmt,
	input  wire logic             pal_valid,
	output logic                  pal_ready,
	input  wire pal_t             pal,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [OUT_W-1:0]      out_data,
	output logic                  out_last
);

	pal_t             blk_q;
	logic             busy_q;
	logic [3:0]       cnt_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic             out_last_q;
	logic             emit, fin;
	logic [1:0]       ci;
	logic [3:0]       anib;
	logic [5:0]       aoff;
	logic [7:0]       alpha;

	assign emit      = busy_q && (!out_valid_q || out_ready);
	assign fin       = emit && (cnt_q == 4'd15);
	assign pal_ready = !busy_q || fin;

	always_comb begin
		ci   = blk_q.cidx[{cnt_q, 1'b0} +: 2];
		anib = blk_q.araw[{cnt_q, 2'b00} +: 4];
		aoff = 6'd16 + 6'(cnt_q) * 6'd3;
		case (fmt)
			// n * 255 / 15 is n * 17, the nibble repeated
			FMT_BC2: alpha = {anib, anib};
			FMT_BC3: alpha = blk_q.apal[blk_q.araw[aoff +: 3]];
			default: alpha = (ci == 2'd3 && !blk_q.c_gt) ? 8'd0 : 8'd255;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pal_ready) begin
				busy_q <= pal_valid;
				cnt_q  <= 4'd0;
			end else if (emit) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pal_ready && pal_valid) blk_q <= pal;
		if (emit) begin
			out_data_q <= {4'd0, alpha, blk_q.rgb[ci][2], blk_q.rgb[ci][1],
				blk_q.rgb[ci][0], cnt_q};
			out_last_q <= (cnt_q == 4'd15);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire
